@@ rtl/ilcp_pkg.sv @@
// ----------------------------------------------------------------------------
// ilcp_pkg: shared types and constants for the integer literal parser
// Holds the parse phase and status codes, the running parse state and the
// character codes used to decode prefixes and digits.
// ----------------------------------------------------------------------------
`default_nettype none

package ilcp_pkg;

	localparam int CHAR_W   = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int DIGIT_W  = 4;
	// accumulator times sixteen plus a digit fits in this width
	localparam int PROD_W   = VALUE_W + DIGIT_W;

	// largest magnitude a literal may reach: 2^31
	localparam logic [PROD_W-1:0] LIMIT = PROD_W'(64'h8000_0000);

	// character codes
	localparam logic [CHAR_W-1:0] CH_0  = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9  = 8'h39;
	localparam logic [CHAR_W-1:0] CH_7  = 8'h37;
	localparam logic [CHAR_W-1:0] CH_LA = 8'h61;
	localparam logic [CHAR_W-1:0] CH_LF = 8'h66;
	localparam logic [CHAR_W-1:0] CH_UA = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UF = 8'h46;
	localparam logic [CHAR_W-1:0] CH_LX = 8'h78;
	localparam logic [CHAR_W-1:0] CH_UX = 8'h58;

	// letters 'a'..'f' and 'A'..'F' carry 1..6 in their low nibble
	localparam logic [DIGIT_W-1:0] HEX_LETTER_OFS = 4'd9;

	typedef enum logic [2:0] {
		PH_START,
		PH_ZERO,
		PH_HEXPREFIX,
		PH_HEX,
		PH_OCT,
		PH_DEC
	} phase_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK,
		ST_RANGE,
		ST_INVALID
	} status_t;

	typedef enum logic [1:0] {
		RAD_DEC,
		RAD_OCT,
		RAD_HEX
	} radix_t;

	typedef struct packed {
		phase_t             phase;
		logic [VALUE_W-1:0] acc;
		status_t            err;
	} state_t;

	localparam state_t STATE_RESET = '{phase: PH_START, acc: '0, err: ST_OK};

endpackage

`default_nettype wire

@@ rtl/ilcp_char_if.sv @@
// ----------------------------------------------------------------------------
// ilcp_char_if: character channel
// Valid/ready channel carrying one literal character and its last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilcp_char_if;
	import ilcp_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] character;
	logic              is_last;

	modport source (output valid, output character, output is_last, input ready);
	modport sink   (input valid, input character, input is_last, output ready);
endinterface

`default_nettype wire

@@ rtl/ilcp_result_if.sv @@
// ----------------------------------------------------------------------------
// ilcp_result_if: result channel
// Valid/ready channel carrying the parsed value and its status.
// ----------------------------------------------------------------------------
`default_nettype none

interface ilcp_result_if;
	import ilcp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output value, output status, input ready);
	modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

@@ rtl/ilcp_digit.sv @@
// ----------------------------------------------------------------------------
// ilcp_digit: one-character parse step
// Works out the next phase from the prefix seen so far, decodes the digit
// for the current radix and does the shift-add with the 2^31 range check.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcp_digit (
	input  wire logic [ilcp_pkg::CHAR_W-1:0] character,
	input  wire ilcp_pkg::state_t            cur,
	output ilcp_pkg::state_t                 nxt
);
	import ilcp_pkg::*;

	phase_t              phase_nxt;
	radix_t              radix;
	logic                take;
	logic                is_x;
	logic                is_num;
	logic                is_letter;
	logic                digit_ok;
	logic [DIGIT_W-1:0]  digit;
	logic [PROD_W-1:0]   prod;
	logic [PROD_W-1:0]   sum;
	logic                over;

	assign is_x      = (character == CH_LX) || (character == CH_UX);
	assign is_num    = (character >= CH_0) && (character <= CH_9);
	assign is_letter = ((character >= CH_LA) && (character <= CH_LF)) ||
	                   ((character >= CH_UA) && (character <= CH_UF));

	// next phase; frozen once an error has been seen
	always_comb begin
		case (cur.phase)
			PH_START:     phase_nxt = (character == CH_0) ? PH_ZERO : PH_DEC;
			PH_ZERO:      phase_nxt = is_x ? PH_HEXPREFIX : PH_OCT;
			PH_HEXPREFIX: phase_nxt = PH_HEX;
			PH_HEX:       phase_nxt = PH_HEX;
			PH_OCT:       phase_nxt = PH_OCT;
			default:      phase_nxt = PH_DEC;
		endcase
		if (cur.err != ST_OK) begin
			phase_nxt = cur.phase;
		end
	end

	// radix in force and whether this character is a digit to accumulate
	always_comb begin
		case (cur.phase)
			PH_START: begin
				radix = RAD_DEC;
				take  = (character != CH_0);
			end
			PH_ZERO: begin
				radix = RAD_OCT;
				take  = !is_x;
			end
			PH_HEXPREFIX, PH_HEX: begin
				radix = RAD_HEX;
				take  = 1'b1;
			end
			PH_OCT: begin
				radix = RAD_OCT;
				take  = 1'b1;
			end
			default: begin
				radix = RAD_DEC;
				take  = 1'b1;
			end
		endcase
		if (cur.err != ST_OK) begin
			take = 1'b0;
		end
	end

	// digit decode
	always_comb begin
		digit = is_letter ? character[DIGIT_W-1:0] + HEX_LETTER_OFS
		                  : character[DIGIT_W-1:0];
		case (radix)
			RAD_HEX: digit_ok = is_num || is_letter;
			RAD_OCT: digit_ok = (character >= CH_0) && (character <= CH_7);
			default: digit_ok = is_num;
		endcase
	end

	// shift-add by the radix
	always_comb begin
		case (radix)
			RAD_HEX: prod = {cur.acc, 4'b0000};
			RAD_OCT: prod = {1'b0, cur.acc, 3'b000};
			default: prod = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0};
		endcase
		sum  = prod + {{(PROD_W-DIGIT_W){1'b0}}, digit};
		over = (sum > LIMIT);
	end

	// next state; first error is kept
	always_comb begin
		nxt.phase = phase_nxt;
		nxt.acc   = cur.acc;
		nxt.err   = cur.err;
		if (take) begin
			if (!digit_ok) begin
				nxt.err = ST_INVALID;
			end else if (over) begin
				nxt.err = ST_RANGE;
			end else begin
				nxt.acc = sum[VALUE_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/ilcp_out_reg.sv @@
// ----------------------------------------------------------------------------
// ilcp_out_reg: result register
// Holds one finished result until the sink takes it; reports room for a new
// one in the same cycle as the current one leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module ilcp_out_reg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                load,
	input  wire logic signed [ilcp_pkg::VALUE_W-1:0] value_d,
	input  wire ilcp_pkg::status_t                   status_d,
	output logic                                     room,
	ilcp_result_if.source                            results
);
	import ilcp_pkg::*;

	logic                      valid_q;
	logic signed [VALUE_W-1:0] value_q;
	status_t                   status_q;

	assign room = !valid_q || results.ready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (room && load) begin
			value_q  <= value_d;
			status_q <= status_d;
		end
	end

	assign results.valid  = valid_q;
	assign results.value  = value_q;
	assign results.status = status_q;

endmodule

`default_nettype wire

@@ rtl/int_literal_char_parser_top.sv @@
// ----------------------------------------------------------------------------
// int_literal_char_parser_top: C-style integer literal parser
// Character stream in, one value/status result per literal out.
// ----------------------------------------------------------------------------
// Takes one character per clock. Each accepted character is registered, then
// applied to the parse state by a combinational shift-add of the accumulator
// (radix 8, 10 or 16, picked from the 0 / 0x / 0X prefix) with a compare
// against 2^31; that update sets the rate of one character per cycle. The
// result for a literal is loaded into the output register when its last
// character leaves the input register, and stays there until taken;
// characters keep flowing meanwhile, and input stalls only when a second
// last character meets a result that has not been taken. The value is 0
// whenever status is not ok; a magnitude of exactly 2^31 comes out as the
// minimum 32-bit integer. The first error of a literal is the one reported.
// ----------------------------------------------------------------------------
`default_nettype none

module int_literal_char_parser_top (
	input  wire logic     clk,
	input  wire logic     arst_n,
	ilcp_char_if.sink     chars,
	ilcp_result_if.source results
);
	import ilcp_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              last_s1;
	state_t            state_q;
	state_t            state_nxt;
	logic              room;
	logic              consume;
	logic              load;
	logic [VALUE_W-1:0] value_d;

	// a character leaves the input register unless its result has no room
	assign consume     = valid_s1 && (!last_s1 || room);
	assign load        = consume && last_s1;
	assign chars.ready = !valid_s1 || consume;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			char_s1 <= chars.character;
			last_s1 <= chars.is_last;
		end
	end

	ilcp_digit u_digit (
		.character (char_s1),
		.cur       (state_q),
		.nxt       (state_nxt)
	);

	// parse state; back to start after the last character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
		end else if (consume) begin
			state_q <= last_s1 ? STATE_RESET : state_nxt;
		end
	end

	assign value_d = (state_nxt.err == ST_OK) ? state_nxt.acc : '0;

	ilcp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.value_d  (value_d),
		.status_d (state_nxt.err),
		.room     (room),
		.results  (results)
	);

`ifndef SYNTHESIS
	a_acc_limit: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q.acc[VALUE_W-1] && (|state_q.acc[VALUE_W-2:0])))
		else $error("accumulator above 2^31");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && (results.status != ST_OK) |-> (results.value == '0))
		else $error("error result with non-zero value");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (state_q.phase == PH_START) && (state_q.err == ST_OK) &&
		         (state_q.acc == '0))
		else $error("parse state not cleared after last character");

	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		consume && !last_s1 && (state_q.err != ST_OK) |=>
		(state_q.err == $past(state_q.err)) && $stable(state_q.acc))
		else $error("error not sticky");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && last_s1 && !room |=> valid_s1 && $stable(char_s1))
		else $error("last character lost while result stalled");
`endif

endmodule

`default_nettype wire
